[hdl/tsl_pkg.sv]
package tsl_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned TABLE_DEPTH_DEF = 4096;
    localparam int unsigned MAX_LEVELS_DEF  = 3;

    // Field widths
    localparam int unsigned LEVEL_W   = 2;
    localparam int unsigned GRID_W    = 10;
    localparam int unsigned SLOT_W    = 12;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned COUNT_W   = 13;
    localparam int unsigned INDEX_W   = 12;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned GRID_N    = 3;

    // Index arithmetic: one grid product, two summed, full linear index
    localparam int unsigned PROD_W    = 2 * GRID_W;
    localparam int unsigned LIN_W     = PROD_W + 2;
    localparam int unsigned ADDR_EXT_W = 32;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 13;

    // Stream packing
    localparam int unsigned S_DATA_W = 104;
    localparam int unsigned M_DATA_W = 80;
    localparam int unsigned ENTRY_W  = 2 * WORD_W;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 2'd0,
        ST_NO_TABLE = 2'd1,
        ST_RANGE    = 2'd2
    } status_t;

    typedef enum logic {
        MODE_LOAD   = 1'b0,
        MODE_LOOKUP = 1'b1
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEVEL_COUNT = 3'd0,
        REG_L0_COLUMNS  = 3'd1,
        REG_L0_ROWS     = 3'd2,
        REG_L1_COLUMNS  = 3'd3,
        REG_L1_ROWS     = 3'd4,
        REG_L2_COLUMNS  = 3'd5,
        REG_L2_ROWS     = 3'd6,
        REG_TILE_COUNT  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]             level_count;
        logic [GRID_N-1:0][GRID_W-1:0]  columns;
        logic [GRID_N-1:0][GRID_W-1:0]  rows;
        logic [COUNT_W-1:0]             tile_count;
    } cfg_t;

    // Request leaving the index pipeline towards the table
    typedef struct packed {
        logic               valid;
        logic               is_load;
        logic               load_ok;
        logic [SLOT_W-1:0]  slot;
        logic [WORD_W-1:0]  offset;
        logic [WORD_W-1:0]  length;
        status_t            status;
        logic [LIN_W-1:0]   lin;
    } table_req_t;

endpackage

[hdl/tile_span_lookup_top.sv]
// Tile span resolver. Each request on the s_ stream is either a load (tuser 0),
// which writes one offset/length pair into the tile table and gives nothing
// back, or a lookup (tuser 1), which gives exactly one response on the m_
// stream: status in m_tuser plus tile index, offset and length (all zero
// unless status is found). One request is taken per clock when the output
// side keeps up; a taken lookup passes the grid-product stage, index-sum
// stage, table read and output register before its response leaves. Loads
// pass the grid-product and index-sum stages and write the table in the cycle a
// lookup would read it, so requests always see the table in request order.
// The table is a single-port-per-cycle synchronous RAM of TABLE_DEPTH 64-bit
// words; it is not cleared, so only slots already loaded may be looked up.
// Configuration (grid sizes, level count, tile count) is written through the
// cfg_ channel, always ready, and must only change while no request is in
// flight.
module tile_span_lookup_top #(
    parameter int unsigned TABLE_DEPTH = tsl_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned MAX_LEVELS  = tsl_pkg::MAX_LEVELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tsl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsl_pkg::CFG_DATA_W-1:0]  cfg_data,

    // Requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [1:0] level, [11:2] column, [21:12] row, [33:22] entry_index,
    // [65:34] entry_offset, [97:66] entry_length, [103:98] zero
    input  logic [tsl_pkg::S_DATA_W-1:0]    s_tdata,
    // [0] mode
    input  logic                            s_tuser,

    // Responses
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [11:0] tile_index, [43:12] span_offset, [75:44] span_length, [79:76] zero
    output logic [tsl_pkg::M_DATA_W-1:0]    m_tdata,
    // [1:0] status
    output logic [tsl_pkg::STATUS_W-1:0]    m_tuser
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);

    tsl_pkg::cfg_t         cfg;
    tsl_pkg::table_req_t   req;

    // Table read stage: RAM output register plus its side band
    logic                          c_valid_reg;
    tsl_pkg::status_t              c_status_reg;
    logic [tsl_pkg::INDEX_W-1:0]   c_index_reg;
    logic [tsl_pkg::ENTRY_W-1:0]   rd_data;

    // Output register
    logic                          out_valid_reg;
    logic [tsl_pkg::M_DATA_W-1:0]  out_data_reg;
    logic [tsl_pkg::STATUS_W-1:0]  out_status_reg;

    logic                          ready_out;
    logic                          ready_c;
    logic                          req_go;
    logic                          wr_en;
    logic                          rd_en;
    logic [tsl_pkg::ADDR_EXT_W-1:0] slot_ext;
    logic [tsl_pkg::ADDR_EXT_W-1:0] lin_ext;
    logic [AW-1:0]                 addr;
    logic                          c_found;
    logic [tsl_pkg::WORD_W-1:0]    span_offset;
    logic [tsl_pkg::WORD_W-1:0]    span_length;

    assign ready_out = !out_valid_reg || m_tready;
    assign ready_c   = !c_valid_reg || ready_out;
    assign req_go    = req.valid && ready_c;

    tsl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tsl_index #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_LEVELS  (MAX_LEVELS)
    ) u_index (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .mode         (s_tuser),
        .level        (s_tdata[1:0]),
        .column       (s_tdata[11:2]),
        .row          (s_tdata[21:12]),
        .entry_index  (s_tdata[33:22]),
        .entry_offset (s_tdata[65:34]),
        .entry_length (s_tdata[97:66]),
        .out_ready    (ready_c),
        .req          (req)
    );

    // Loads and lookups share one address; only one request sits here per cycle
    assign slot_ext = tsl_pkg::ADDR_EXT_W'(req.slot);
    assign lin_ext  = tsl_pkg::ADDR_EXT_W'(req.lin);
    assign addr     = req.is_load ? slot_ext[AW-1:0] : lin_ext[AW-1:0];
    assign wr_en    = req_go && req.is_load && req.load_ok;
    assign rd_en    = req_go && !req.is_load && (req.status == tsl_pkg::ST_FOUND);

    tsl_ram #(
        .WIDTH (tsl_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr),
        .wr_data ({req.length, req.offset}),
        .rd_en   (rd_en),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (ready_c)
        begin
            c_valid_reg <= req.valid && !req.is_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_go && !req.is_load)
        begin
            c_status_reg <= req.status;
            c_index_reg  <= req.lin[tsl_pkg::INDEX_W-1:0];
        end
    end

    // Anything but found answers with zeros
    assign c_found     = (c_status_reg == tsl_pkg::ST_FOUND);
    assign span_offset = c_found ? rd_data[tsl_pkg::WORD_W-1:0] : '0;
    assign span_length = c_found ? rd_data[tsl_pkg::ENTRY_W-1:tsl_pkg::WORD_W] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            out_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_out && c_valid_reg)
        begin
            out_status_reg <= c_status_reg;
            out_data_reg   <= {4'b0000, span_length, span_offset,
                               (c_found ? c_index_reg : tsl_pkg::INDEX_W'(0))};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

[hdl/tsl_ram.sv]
module tsl_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 4096,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/tsl_cfg.sv]
module tsl_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tsl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsl_pkg::CFG_DATA_W-1:0]  cfg_data,
    output tsl_pkg::cfg_t                   cfg
);

    tsl_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (tsl_pkg::cfg_reg_t'(cfg_index))
                tsl_pkg::REG_LEVEL_COUNT:
                    cfg_reg.level_count <= cfg_data[tsl_pkg::LEVEL_W-1:0];
                tsl_pkg::REG_L0_COLUMNS:
                    cfg_reg.columns[0] <= cfg_data[tsl_pkg::GRID_W-1:0];
                tsl_pkg::REG_L0_ROWS:
                    cfg_reg.rows[0] <= cfg_data[tsl_pkg::GRID_W-1:0];
                tsl_pkg::REG_L1_COLUMNS:
                    cfg_reg.columns[1] <= cfg_data[tsl_pkg::GRID_W-1:0];
                tsl_pkg::REG_L1_ROWS:
                    cfg_reg.rows[1] <= cfg_data[tsl_pkg::GRID_W-1:0];
                tsl_pkg::REG_L2_COLUMNS:
                    cfg_reg.columns[2] <= cfg_data[tsl_pkg::GRID_W-1:0];
                tsl_pkg::REG_L2_ROWS:
                    cfg_reg.rows[2] <= cfg_data[tsl_pkg::GRID_W-1:0];
                tsl_pkg::REG_TILE_COUNT:
                    cfg_reg.tile_count <= cfg_data;
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

[hdl/tsl_index.sv]
module tsl_index #(
    parameter int unsigned TABLE_DEPTH = tsl_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned MAX_LEVELS  = tsl_pkg::MAX_LEVELS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tsl_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        mode,
    input  logic [tsl_pkg::LEVEL_W-1:0] level,
    input  logic [tsl_pkg::GRID_W-1:0]  column,
    input  logic [tsl_pkg::GRID_W-1:0]  row,
    input  logic [tsl_pkg::SLOT_W-1:0]  entry_index,
    input  logic [tsl_pkg::WORD_W-1:0]  entry_offset,
    input  logic [tsl_pkg::WORD_W-1:0]  entry_length,
    input  logic                        out_ready,
    output tsl_pkg::table_req_t         req
);

    localparam logic [tsl_pkg::LEVEL_W-1:0] LEVEL_LIMIT = tsl_pkg::LEVEL_W'(MAX_LEVELS);
    localparam logic [tsl_pkg::ADDR_EXT_W-1:0] DEPTH_EXT =
        tsl_pkg::ADDR_EXT_W'(TABLE_DEPTH);

    // Stage A: grid products and position checks
    logic                         a_valid_reg;
    logic                         a_load_reg;
    logic                         a_load_ok_reg;
    logic [tsl_pkg::SLOT_W-1:0]   a_slot_reg;
    logic [tsl_pkg::WORD_W-1:0]   a_offset_reg;
    logic [tsl_pkg::WORD_W-1:0]   a_length_reg;
    tsl_pkg::status_t             a_status_reg;
    logic [tsl_pkg::LEVEL_W-1:0]  a_level_reg;
    logic [tsl_pkg::GRID_W-1:0]   a_col_reg;
    logic [tsl_pkg::PROD_W-1:0]   a_p0_reg;
    logic [tsl_pkg::PROD_W-1:0]   a_p1_reg;
    logic [tsl_pkg::PROD_W-1:0]   a_prow_reg;

    // Stage B: linear index and table-bound check
    tsl_pkg::table_req_t          b_reg;
    tsl_pkg::table_req_t          b_next;

    logic                         a_ready;
    logic                         b_ready;
    logic                         in_go;
    logic [tsl_pkg::LEVEL_W-1:0]  levels;
    logic [tsl_pkg::GRID_W-1:0]   cols_sel;
    logic [tsl_pkg::GRID_W-1:0]   rows_sel;
    tsl_pkg::status_t             status_a_next;
    logic [tsl_pkg::LIN_W-1:0]    base;
    logic [tsl_pkg::LIN_W-1:0]    lin;

    assign b_ready  = !b_reg.valid || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;
    assign in_go    = in_valid && a_ready;
    assign req      = b_reg;

    assign levels = (cfg.level_count < LEVEL_LIMIT) ? cfg.level_count : LEVEL_LIMIT;

    always_comb
    begin
        case (level)
            2'd0:    begin cols_sel = cfg.columns[0]; rows_sel = cfg.rows[0]; end
            2'd1:    begin cols_sel = cfg.columns[1]; rows_sel = cfg.rows[1]; end
            2'd2:    begin cols_sel = cfg.columns[2]; rows_sel = cfg.rows[2]; end
            default: begin cols_sel = '0;             rows_sel = '0;          end
        endcase

        if (cfg.tile_count == '0)
        begin
            status_a_next = tsl_pkg::ST_NO_TABLE;
        end
        else if (level >= levels || column >= cols_sel || row >= rows_sel)
        begin
            status_a_next = tsl_pkg::ST_RANGE;
        end
        else
        begin
            status_a_next = tsl_pkg::ST_FOUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_go)
        begin
            a_load_reg    <= (tsl_pkg::mode_t'(mode) == tsl_pkg::MODE_LOAD);
            a_load_ok_reg <= tsl_pkg::ADDR_EXT_W'(entry_index) < DEPTH_EXT;
            a_slot_reg    <= entry_index;
            a_offset_reg  <= entry_offset;
            a_length_reg  <= entry_length;
            a_status_reg  <= status_a_next;
            a_level_reg   <= level;
            a_col_reg     <= column;
            a_p0_reg      <= cfg.columns[0] * cfg.rows[0];
            a_p1_reg      <= cfg.columns[1] * cfg.rows[1];
            a_prow_reg    <= row * cols_sel;
        end
    end

    always_comb
    begin
        case (a_level_reg)
            2'd1:    base = tsl_pkg::LIN_W'(a_p0_reg);
            2'd2:    base = tsl_pkg::LIN_W'(a_p0_reg) + tsl_pkg::LIN_W'(a_p1_reg);
            default: base = '0;
        endcase
        lin = base + tsl_pkg::LIN_W'(a_prow_reg) + tsl_pkg::LIN_W'(a_col_reg);

        b_next         = '0;
        b_next.valid   = a_valid_reg;
        b_next.is_load = a_load_reg;
        b_next.load_ok = a_load_ok_reg;
        b_next.slot    = a_slot_reg;
        b_next.offset  = a_offset_reg;
        b_next.length  = a_length_reg;
        b_next.lin     = lin;
        b_next.status  = a_status_reg;
        if (a_status_reg == tsl_pkg::ST_FOUND &&
            (lin >= tsl_pkg::LIN_W'(cfg.tile_count) ||
             tsl_pkg::ADDR_EXT_W'(lin) >= DEPTH_EXT))
        begin
            b_next.status = tsl_pkg::ST_RANGE;
        end
    end

    // Side band only moves when stage A actually holds a request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
        end
        else if (b_ready)
        begin
            b_reg.valid <= b_next.valid;
            if (a_valid_reg)
            begin
                b_reg.is_load <= b_next.is_load;
                b_reg.load_ok <= b_next.load_ok;
                b_reg.slot    <= b_next.slot;
                b_reg.offset  <= b_next.offset;
                b_reg.length  <= b_next.length;
                b_reg.status  <= b_next.status;
                b_reg.lin     <= b_next.lin;
            end
        end
    end

endmodule
